@@ sv/button_press_classifier_unit_defines.svh @@
// ----------------------------------------------------------------------------
// button press classifier assertion macros
// shared property forms for the classifier's concurrent checks
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BPC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("button press classifier check failed");

// next-cycle implication, quiet during reset
`define BPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("button press classifier check failed");

`endif

@@ sv/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// button press classifier package
// payload types, state record, register indexes, event codes and reset defaults
// ----------------------------------------------------------------------------
package bpc_pkg;

	typedef struct packed {
		logic        raw_level;
		logic [31:0] time_ms;
	} bpc_in_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic [3:0] profile_index;
		logic       debounced_level;
	} bpc_out_t;

	typedef struct packed {
		logic [15:0] debounce_time;
		logic [15:0] long_press_time;
		logic [15:0] reset_hold_time;
	} bpc_cfg_t;

	typedef struct packed {
		logic        previous_raw;
		logic        stable_level;
		logic [31:0] last_change_time;
		logic [31:0] press_start_time;
		logic        long_press_done;
		logic        reset_event_done;
		logic [3:0]  current_profile;
	} bpc_state_t;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_TOGGLE  = 2'd1;
	localparam logic [1:0] EV_PROFILE = 2'd2;
	localparam logic [1:0] EV_RESET   = 2'd3;

	localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [1:0] REG_RESET_HOLD = 2'd2;

	localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [15:0] RESET_HOLD_RST = 16'd10000;

endpackage

@@ sv/bpc_step.sv @@
// ----------------------------------------------------------------------------
// button press classifier step logic
// debounce, press timing and event decision for one sample
// ----------------------------------------------------------------------------
module bpc_step #(
	parameter int unsigned NUM_PROFILES = 4
) (
	input  bpc_pkg::bpc_state_t st,
	input  bpc_pkg::bpc_cfg_t   cfg,
	input  bpc_pkg::bpc_in_t    smp,
	output bpc_pkg::bpc_state_t st_nxt,
	output bpc_pkg::bpc_out_t   res
);
	import bpc_pkg::*;

	logic [31:0] change_time;
	logic [31:0] steady_ms;
	logic [31:0] held_ms;
	logic [3:0]  profile_inc;
	logic [1:0]  ev;

	assign change_time = (smp.raw_level != st.previous_raw) ? smp.time_ms : st.last_change_time;
	assign steady_ms   = smp.time_ms - change_time;
	assign held_ms     = smp.time_ms - st.press_start_time;
	assign profile_inc = (st.current_profile == 4'(NUM_PROFILES - 1)) ? 4'd0
		: st.current_profile + 4'd1;

	always_comb begin
		st_nxt = st;
		st_nxt.previous_raw = smp.raw_level;
		st_nxt.last_change_time = change_time;
		ev = EV_NONE;
		if (steady_ms < {16'd0, cfg.debounce_time}) begin
			ev = EV_NONE;
		end else if (smp.raw_level != st.stable_level) begin
			st_nxt.stable_level = smp.raw_level;
			if (!smp.raw_level) begin
				st_nxt.press_start_time = smp.time_ms;
				st_nxt.long_press_done = 1'b0;
				st_nxt.reset_event_done = 1'b0;
			end else begin
				ev = st.long_press_done ? EV_NONE : EV_TOGGLE;
			end
		end else if (st.stable_level) begin
			ev = EV_NONE;
		end else if (!st.reset_event_done && held_ms >= {16'd0, cfg.reset_hold_time}) begin
			// factory reset wins over profile advance in the same step
			st_nxt.reset_event_done = 1'b1;
			ev = EV_RESET;
		end else if (!st.long_press_done && held_ms >= {16'd0, cfg.long_press_time}) begin
			st_nxt.long_press_done = 1'b1;
			st_nxt.current_profile = profile_inc;
			ev = EV_PROFILE;
		end
	end

	assign res.event_code      = ev;
	assign res.profile_index   = st_nxt.current_profile;
	assign res.debounced_level = st_nxt.stable_level;

endmodule

@@ sv/button_press_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// button press classifier
// debounced short/long press and hold detector for one active-low button
// ----------------------------------------------------------------------------
// channel   handshake              payload
// sample    sample_valid/_stall    sample_data  (raw_level, time_ms)
// result    result_valid/_stall    result_data  (event_code, profile_index,
//                                                debounced_level)
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data (16 bit)
//
// one sample per clock while sample_stall is low; a sample is registered,
// evaluated and its result is registered in the result stage
// every sample gives exactly one result
// a stalled result holds; the input register keeps taking samples until it
// is also full, then sample_stall follows result_stall
// reset restores the default thresholds, released level and profile zero
// ----------------------------------------------------------------------------
`include "button_press_classifier_unit_defines.svh"

module button_press_classifier_unit #(
	parameter int unsigned NUM_PROFILES = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  bpc_pkg::bpc_in_t   sample_data,
	output logic               result_valid,
	input  logic               result_stall,
	output bpc_pkg::bpc_out_t  result_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import bpc_pkg::*;

	bpc_cfg_t   cfg_q;
	bpc_state_t st_q;
	bpc_state_t st_nxt;
	bpc_in_t    smp_s1;
	logic       valid_s1;
	bpc_out_t   res_s2;
	bpc_out_t   res_nxt;
	logic       valid_s2;
	logic       advance;

	assign advance      = !valid_s2 || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign cfg_ready    = 1'b1;
	assign result_valid = valid_s2;
	assign result_data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= DEBOUNCE_RST;
			cfg_q.long_press_time <= LONG_PRESS_RST;
			cfg_q.reset_hold_time <= RESET_HOLD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_time <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_time <= cfg_data;
				REG_RESET_HOLD: cfg_q.reset_hold_time <= cfg_data;
				default: ;
			endcase
		end
	end

	bpc_step #(
		.NUM_PROFILES(NUM_PROFILES)
	) u_step (
		.st     (st_q),
		.cfg    (cfg_q),
		.smp    (smp_s1),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			smp_s1 <= sample_data;
		end
	end

	// state moves only when the registered sample is handed to the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.previous_raw     <= 1'b1;
			st_q.stable_level     <= 1'b1;
			st_q.last_change_time <= '0;
			st_q.press_start_time <= '0;
			st_q.long_press_done  <= 1'b0;
			st_q.reset_event_done <= 1'b0;
			st_q.current_profile  <= '0;
		end else if (valid_s1 && advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_nxt;
		end
	end

	`BPC_ASSERT_NEXT(a_handoff_gives_result, valid_s1 && advance, valid_s2)
	`BPC_ASSERT_NOW(a_profile_in_range, 1'b1, st_q.current_profile <= 4'(NUM_PROFILES - 1))
	`BPC_ASSERT_NOW(a_reset_while_pressed,
		valid_s2 && res_s2.event_code == EV_RESET, !res_s2.debounced_level)

endmodule
